// File: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define BRZ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("brz assertion failed");

// checked at every edge, reset included
`define BRZ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("brz assertion failed");

`endif

// File: src/brz_pkg.sv
package brz_pkg;

  localparam int MaxSrcHeight   = 64;
  localparam int MaxSrcWidth    = 64;
  localparam int WeightFracBits = 8;

  localparam int CoordW  = 10;
  localparam int SampleW = 16;
  localparam int SizeW   = 7;
  localparam int TgtW    = 11;

  localparam int RowIdxW  = (MaxSrcHeight > 1) ? $clog2(MaxSrcHeight) : 1;
  localparam int ColIdxW  = (MaxSrcWidth > 1) ? $clog2(MaxSrcWidth) : 1;
  localparam int AddrW    = RowIdxW + ColIdxW;
  localparam int RamDepth = 1 << AddrW;

  // destination coordinate times source size, then scaled by the weight bits
  localparam int NumW  = CoordW + SizeW;
  localparam int QuotW = NumW + WeightFracBits;
  localparam int RemW  = TgtW;

  localparam int InDataW  = ((2 * CoordW + SampleW + 7) / 8) * 8;
  localparam int OutDataW = ((SampleW + 7) / 8) * 8;
  localparam int CfgAddrW = 4;

  typedef enum logic [1:0] {
    REG_SRC_H = 2'd0,
    REG_SRC_W = 2'd1,
    REG_TGT_H = 2'd2,
    REG_TGT_W = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic vld;
    logic query;
    logic oor;
  } ctl_t;

  typedef struct packed {
    logic               query;
    logic               oor;
    logic               load_ok;
    logic [RowIdxW-1:0] row_idx;
    logic [ColIdxW-1:0] col_idx;
    logic [SampleW-1:0] sample;
  } pl_t;

  // zero acts as one, anything above the store size acts as the store size
  function automatic logic [SizeW-1:0] eff_size(logic [SizeW-1:0] r, int maxv);
    logic [SizeW-1:0] res;
    if (r == '0) begin
      res = SizeW'(1);
    end else if (int'(r) > maxv) begin
      res = SizeW'(maxv);
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

// File: src/bilinear_map_resize_unit.sv
// Bilinear map resizer. Load words (tuser 0) write one signed sample into the
// source store at row/col, dropped when outside the programmed source size;
// query words (tuser 1) return one interpolated sample for a destination
// pixel, with tuser set and value 0 when the pixel lies outside the target
// size. One word is taken every cycle. A query passes the coordinate multiply
// register, the bit-per-stage divider that yields source index and weight,
// the store read register, the horizontal and vertical interpolation registers
// and the output register. A skid register behind the output register catches
// one more result while the output word is not taken; input stalls only while
// that skid register is full. Words leave in order. Sizes must be written over
// the register port only while the pipeline is empty; the block does not
// enforce this. Samples come from four copies of the store, each read once
// per cycle unless stalled; a sample never loaded reads as garbage.
module bilinear_map_resize_unit import brz_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // row, col, sample, zero pad
  input  logic [0:0]          s_axis_tuser,   // opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // value
  output logic [0:0]          m_axis_tuser,   // out_of_range
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int K = WeightFracBits;

  logic [SizeW-1:0] src_h_q, src_w_q;
  logic [TgtW-1:0]  tgt_h_q, tgt_w_q;
  logic [SizeW-1:0] sh, sw;
  cfg_reg_e         cfg_idx;
  logic             cfg_wr;
  logic             adv;

  // ---------------- register port
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_h_q <= SizeW'(64);
      src_w_q <= SizeW'(64);
      tgt_h_q <= TgtW'(64);
      tgt_w_q <= TgtW'(64);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_H: src_h_q <= pwdata[SizeW-1:0];
        REG_SRC_W: src_w_q <= pwdata[SizeW-1:0];
        REG_TGT_H: tgt_h_q <= pwdata[TgtW-1:0];
        REG_TGT_W: tgt_w_q <= pwdata[TgtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SRC_H: prdata = 32'(src_h_q);
      REG_SRC_W: prdata = 32'(src_w_q);
      REG_TGT_H: prdata = 32'(tgt_h_q);
      REG_TGT_W: prdata = 32'(tgt_w_q);
      default:   prdata = '0;
    endcase
  end

  assign sh = eff_size(src_h_q, MaxSrcHeight);
  assign sw = eff_size(src_w_q, MaxSrcWidth);

  // ---------------- input stage
  logic               out_vld_q;
  logic               skid_vld_q;
  logic [CoordW-1:0]  in_row, in_col;
  logic [SampleW-1:0] in_smp;
  pl_t                s0_pl_d, s0_pl_q;
  logic               s0_vld_q;
  logic [NumW-1:0]    num_y_q, num_x_q;

  // whole pipeline moves unless a word waits in the skid register
  assign adv           = !skid_vld_q;
  assign s_axis_tready = adv;

  assign in_row = s_axis_tdata[CoordW-1:0];
  assign in_col = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_smp = s_axis_tdata[2*CoordW+SampleW-1:2*CoordW];

  always_comb begin
    s0_pl_d.query   = (op_e'(s_axis_tuser[0]) == OP_QUERY);
    s0_pl_d.oor     = (TgtW'(in_row) >= tgt_h_q) | (TgtW'(in_col) >= tgt_w_q);
    s0_pl_d.load_ok = (in_row < CoordW'(sh)) & (in_col < CoordW'(sw));
    s0_pl_d.row_idx = in_row[RowIdxW-1:0];
    s0_pl_d.col_idx = in_col[ColIdxW-1:0];
    s0_pl_d.sample  = in_smp;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_pl_q <= s0_pl_d;
      num_y_q <= NumW'(in_row) * NumW'(sh);
      num_x_q <= NumW'(in_col) * NumW'(sw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  // ---------------- coordinate dividers, payload delayed alongside
  logic [QuotW-1:0] quot_y, quot_x;
  pl_t              pl_dl_q  [QuotW];
  logic [QuotW-1:0] vld_dl_q;

  brz_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num_y_q),
    .den_i  (tgt_h_q),
    .quot_o (quot_y)
  );

  brz_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num_x_q),
    .den_i  (tgt_w_q),
    .quot_o (quot_x)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl_dl_q[0] <= s0_pl_q;
      for (int j = 1; j < QuotW; j++) begin
        pl_dl_q[j] <= pl_dl_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_dl_q <= '0;
    end else if (adv) begin
      vld_dl_q <= {vld_dl_q[QuotW-2:0], s0_vld_q};
    end
  end

  // ---------------- neighbor indices and store access
  pl_t                pa;
  logic               va;
  logic [NumW-1:0]    qy, qx, qy_c, qx_c, y1_n, x1_n, last_y, last_x;
  logic [RowIdxW-1:0] y0, y1;
  logic [ColIdxW-1:0] x0, x1;
  logic [AddrW-1:0]   raddr [4];
  logic [SampleW-1:0] rdata [4];
  logic               ram_we;
  logic [AddrW-1:0]   waddr;

  assign pa = pl_dl_q[QuotW-1];
  assign va = vld_dl_q[QuotW-1];

  always_comb begin
    qy     = quot_y[QuotW-1:K];
    qx     = quot_x[QuotW-1:K];
    last_y = NumW'(sh) - NumW'(1);
    last_x = NumW'(sw) - NumW'(1);
    qy_c   = (qy > last_y) ? last_y : qy;
    qx_c   = (qx > last_x) ? last_x : qx;
    // second neighbor clamps at the last row / column
    y1_n   = (qy_c < last_y) ? qy_c + NumW'(1) : last_y;
    x1_n   = (qx_c < last_x) ? qx_c + NumW'(1) : last_x;
    y0     = qy_c[RowIdxW-1:0];
    y1     = y1_n[RowIdxW-1:0];
    x0     = qx_c[ColIdxW-1:0];
    x1     = x1_n[ColIdxW-1:0];
  end

  assign raddr[0] = {y0, x0};
  assign raddr[1] = {y0, x1};
  assign raddr[2] = {y1, x0};
  assign raddr[3] = {y1, x1};

  assign ram_we = adv & va & !pa.query & pa.load_ok;
  assign waddr  = {pa.row_idx, pa.col_idx};

  for (genvar i = 0; i < 4; i++) begin : g_store
    brz_ram #(
      .Width (SampleW),
      .Depth (RamDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (waddr),
      .wdata_i (pa.sample),
      .re_i    (adv),
      .raddr_i (raddr[i]),
      .rdata_o (rdata[i])
    );
  end

  ctl_t         sb_ctl_q;
  logic [K-1:0] sb_fx_q, sb_fy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_fx_q <= quot_x[K-1:0];
      sb_fy_q <= quot_y[K-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_ctl_q <= '0;
    end else if (adv) begin
      sb_ctl_q <= '{vld: va, query: pa.query, oor: pa.oor};
    end
  end

  // ---------------- interpolation and output word
  ctl_t                      ictl;
  logic signed [SampleW-1:0] ivalue;
  logic [SampleW-1:0]        value_q;
  logic                      oor_q;
  logic [SampleW-1:0]        skid_value_q;
  logic                      skid_oor_q;
  logic                      w_vld;
  logic [SampleW-1:0]        w_value;
  logic                      out_take;

  brz_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctl_i   (sb_ctl_q),
    .s00_i   ($signed(rdata[0])),
    .s01_i   ($signed(rdata[1])),
    .s10_i   ($signed(rdata[2])),
    .s11_i   ($signed(rdata[3])),
    .fx_i    (sb_fx_q),
    .fy_i    (sb_fy_q),
    .ctl_o   (ictl),
    .value_o (ivalue)
  );

  assign w_vld    = ictl.vld & ictl.query;
  assign w_value  = ictl.oor ? '0 : ivalue;
  assign out_take = !out_vld_q | m_axis_tready;

  // output register refills from the skid register first
  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_vld_q) begin
        value_q <= skid_value_q;
        oor_q   <= skid_oor_q;
      end else begin
        value_q <= w_value;
        oor_q   <= ictl.oor;
      end
    end
    if (adv && !out_take) begin
      skid_value_q <= w_value;
      skid_oor_q   <= ictl.oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_take) begin
        out_vld_q <= skid_vld_q | w_vld;
      end
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end else if (adv) begin
        skid_vld_q <= w_vld;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(value_q);
  assign m_axis_tuser  = oor_q;

endmodule

// File: src/brz_ram.sv
module brz_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/brz_div.sv
module brz_div import brz_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [TgtW-1:0]  den_i,
  output logic [QuotW-1:0] quot_o
);

  // one quotient bit per stage; quotient bits shift in behind the dividend
  logic [RemW-1:0]  rem_q [QuotW];
  logic [QuotW-1:0] dq_q  [QuotW];
  logic [RemW-1:0]  rem_d [QuotW];
  logic [QuotW-1:0] dq_d  [QuotW];

  for (genvar j = 0; j < QuotW; j++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [QuotW-1:0] dq_in;
    logic [RemW:0]    trial;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = {num_i, {WeightFracBits{1'b0}}};
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dq_in  = dq_q[j-1];
    end

    assign trial = {rem_in, dq_in[QuotW-1]};

    always_comb begin
      if (trial >= {1'b0, den_i}) begin
        rem_d[j] = RemW'(trial - {1'b0, den_i});
        dq_d[j]  = {dq_in[QuotW-2:0], 1'b1};
      end else begin
        rem_d[j] = RemW'(trial);
        dq_d[j]  = {dq_in[QuotW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d[j];
        dq_q[j]  <= dq_d[j];
      end
    end
  end

  assign quot_o = dq_q[QuotW-1];

endmodule

// File: src/brz_interp.sv
module brz_interp import brz_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  ctl_t                      ctl_i,
  input  logic signed [SampleW-1:0] s00_i,
  input  logic signed [SampleW-1:0] s01_i,
  input  logic signed [SampleW-1:0] s10_i,
  input  logic signed [SampleW-1:0] s11_i,
  input  logic [WeightFracBits-1:0] fx_i,
  input  logic [WeightFracBits-1:0] fy_i,
  output ctl_t                      ctl_o,
  output logic signed [SampleW-1:0] value_o
);

  localparam int K   = WeightFracBits;
  localparam int DW  = SampleW + 1;
  localparam int HW  = SampleW + K + 2;
  localparam int DHW = HW + 1;
  localparam int PW  = DHW + K + 1;
  localparam int SW  = PW + 1;

  localparam logic signed [SW-1:0] MaxV = SW'((2 ** (SampleW - 1)) - 1);
  localparam logic signed [SW-1:0] MinV = -SW'(2 ** (SampleW - 1));

  logic signed [DW-1:0]  d0, d1;
  logic signed [HW-1:0]  m0, m1;
  logic signed [HW-1:0]  h0_d, h1_d, h0_q, h1_q;
  logic [K-1:0]          fy_q;
  ctl_t                  c1_q, c2_q;
  logic signed [DHW-1:0] dh;
  logic signed [PW-1:0]  mp;
  logic signed [SW-1:0]  sum_d, sum_q, rnd, res;

  // horizontal pass: s0 * 2^k + (s1 - s0) * fx
  always_comb begin
    d0   = DW'(s01_i) - DW'(s00_i);
    d1   = DW'(s11_i) - DW'(s10_i);
    m0   = HW'(d0) * HW'($signed({1'b0, fx_i}));
    m1   = HW'(d1) * HW'($signed({1'b0, fx_i}));
    h0_d = (HW'(s00_i) <<< K) + m0;
    h1_d = (HW'(s10_i) <<< K) + m1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
      fy_q <= fy_i;
    end
  end

  // vertical pass
  always_comb begin
    dh    = DHW'(h1_q) - DHW'(h0_q);
    mp    = PW'(dh) * PW'($signed({1'b0, fy_q}));
    sum_d = (SW'(h0_q) <<< K) + SW'(mp);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
    end
  end

  // round half up, then clip to the sample range
  always_comb begin
    rnd = sum_q + (SW'(1) <<< (2 * K - 1));
    res = rnd >>> (2 * K);
    if (res > MaxV) begin
      value_o = SampleW'(MaxV);
    end else if (res < MinV) begin
      value_o = SampleW'(MinV);
    end else begin
      value_o = res[SampleW-1:0];
    end
  end

  assign ctl_o = c2_q;

endmodule

// File: src/brz_checker.sv
`include "assert_macros.svh"

module brz_checker import brz_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser,
  input logic                pready
);

  // a flagged pixel carries a zero value
  `BRZ_ASSERT(a_oor_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)

  `BRZ_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  `BRZ_ASSERT_ALWAYS(a_pready, clk_i, pready)

  `BRZ_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind bilinear_map_resize_unit brz_checker u_brz_checker (.*);

// File: tb/testbench.sv
module testbench;
  import brz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class resize_scoreboard;
    logic [SizeW-1:0] src_h, src_w;
    logic [TgtW-1:0]  tgt_h, tgt_w;
    logic signed [15:0] store [0:MaxSrcHeight*MaxSrcWidth-1];
    logic [16:0] pending_q[$];
    int errors;
    int n_results;

    function void reset_state();
      src_h = SizeW'(64); src_w = SizeW'(64); tgt_h = TgtW'(64); tgt_w = TgtW'(64);
      foreach (store[i]) store[i] = '0;
      errors = 0;
      n_results = 0;
    endfunction

    function int clamp_size(int r, int maxv);
      int res;
      res = r;
      if (r == 0) res = 1;
      else if (r > maxv) res = maxv;
      return res;
    endfunction

    function void map_axis(int d, int src, int dst, output int i0, output int i1,
                           output int w);
      int num, q, rem;
      num = d * src;
      q = num / dst;
      rem = num % dst;
      if (q > src - 1) q = src - 1;
      i0 = q;
      i1 = (q + 1 < src) ? q + 1 : src - 1;
      w = (rem << WeightFracBits) / dst;
    endfunction

    function longint pix(int r, int c);
      return longint'(store[r*MaxSrcWidth + c]);
    endfunction

    // accepted input word: update store or queue the interpolated value
    function void note_input(op_e op, int r, int c, logic signed [15:0] s);
      int sh, sw, y0, y1, fy, x0, x1, fx;
      longint one, h0, h1, sum, res;
      sh = clamp_size(src_h, MaxSrcHeight);
      sw = clamp_size(src_w, MaxSrcWidth);
      if (op == OP_LOAD) begin
        if (r < sh && c < sw) store[r*MaxSrcWidth + c] = s;
        return;
      end
      if (r >= tgt_h || c >= tgt_w) begin
        pending_q.insert(pending_q.size(), {1'b1, 16'h0});
        return;
      end
      map_axis(r, sh, tgt_h, y0, y1, fy);
      map_axis(c, sw, tgt_w, x0, x1, fx);
      one = 1 << WeightFracBits;
      h0 = pix(y0, x0) * (one - fx) + pix(y0, x1) * fx;
      h1 = pix(y1, x0) * (one - fx) + pix(y1, x1) * fx;
      sum = h0 * (one - fy) + h1 * fy + (longint'(1) << (2*WeightFracBits - 1));
      res = sum >>> (2*WeightFracBits);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      pending_q.insert(pending_q.size(), {1'b0, res[15:0]});
    endfunction

    function void check_result(logic [15:0] value, logic oor);
      logic [16:0] exp;
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word value=%h oor=%b", $time, value, oor);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (exp[16] !== oor) begin
        $display("%0t: oor mismatch expected %b actual %b", $time, exp[16], oor);
        errors++;
      end
      if (exp[15:0] !== value) begin
        $display("%0t: value mismatch expected %h actual %h", $time, exp[15:0], value);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  bilinear_map_resize_unit DUT (.*);

  resize_scoreboard resize_sb;
  bit idle_enable;
  longint cycle_count = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      resize_sb.check_result(m_axis_tdata[15:0], m_axis_tuser[0]);

  // receiver stalls in bursts
  initial begin
    int n;
    m_axis_tready = 1;
    forever begin
      @(negedge clk_i);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 0;
        repeat (n) @(negedge clk_i);
        m_axis_tready <= 1;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, int val);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= CfgAddrW'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SRC_H: resize_sb.src_h = SizeW'(val);
      REG_SRC_W: resize_sb.src_w = SizeW'(val);
      REG_TGT_H: resize_sb.tgt_h = TgtW'(val);
      REG_TGT_W: resize_sb.tgt_w = TgtW'(val);
    endcase
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(op_e op, int r, int c, logic [15:0] s);
    int n;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      s_axis_tvalid <= 0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= InDataW'({s, 10'(c), 10'(r)});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    resize_sb.note_input(op, r, c, s);
  endtask

  task automatic end_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    while (resize_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // fill the whole active source area so every query reads written entries
  task automatic fill_source(int sh, int sw, int mode);
    logic [15:0] v;
    for (int r = 0; r < sh; r++)
      for (int c = 0; c < sw; c++) begin
        case (mode)
          0: v = 16'h7fff;
          1: v = 16'h8000;
          default: v = 16'($urandom);
        endcase
        send_word(OP_LOAD, r, c, v);
      end
  endtask

  task automatic run_phase(int sh, int sw, int th, int tw, int n, int mode);
    int r, c;
    write_reg(REG_SRC_H, sh);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_TGT_H, th);
    write_reg(REG_TGT_W, tw);
    fill_source(resize_sb.clamp_size(sh, MaxSrcHeight),
                resize_sb.clamp_size(sw, MaxSrcWidth), mode);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // random load, possibly out of range, full field values
        send_word(OP_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  16'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        send_word(OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  16'($urandom));
      end else begin
        r = (th > 0) ? $urandom_range(0, th - 1) : 0;
        c = (tw > 0) ? $urandom_range(0, tw - 1) : 0;
        send_word(OP_QUERY, r, c, 16'($urandom));
      end
    end
    end_stream();
    drain();
  endtask

  initial begin
    resize_sb = new();
    resize_sb.reset_state();
    idle_enable = 0;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: extreme samples, corners, out of range loads and queries
    run_phase(2, 2, 3, 3, 0, 0);
    send_word(OP_QUERY, 0, 0, 0);
    send_word(OP_QUERY, 2, 2, 16'hffff);
    send_word(OP_QUERY, 3, 0, 0);
    send_word(OP_QUERY, 0, 3, 0);
    send_word(OP_QUERY, 1023, 1023, 0);
    send_word(OP_LOAD, 2, 0, 16'h1234);
    send_word(OP_LOAD, 1023, 1023, 16'h8000);
    send_word(OP_LOAD, 0, 1, 16'h8000);
    send_word(OP_QUERY, 1, 1, 0);
    send_word(OP_QUERY, 2, 1, 0);
    end_stream();
    drain();
    run_phase(1, 1, 1, 1, 4, 1);
    run_phase(0, 0, 0, 0, 4, 2);
    run_phase(127, 1, 5, 5, 10, 2);

    idle_enable = 1;
    run_phase(4, 5, 1024, 1024, 400, 2);
    run_phase(2, 127, 1, 1024, 200, 2);
    run_phase(7, 3, 2, 9, 400, 2);
    run_phase(8, 8, 64, 17, 400, 2);
    idle_enable = 0;
    run_phase(3, 6, 11, 1000, 300, 2);

    $display("covered %0d results over load/query mixes, source sizes 0..127",
             resize_sb.n_results);
    $display("and target sizes 0..1024 with random stalls on both sides");
    if (resize_sb.errors == 0 && resize_sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/brz_pkg.sv
src/brz_ram.sv
src/brz_div.sv
src/brz_interp.sv
src/bilinear_map_resize_unit.sv
src/brz_checker.sv
tb/testbench.sv
